// ===== src/ibmw_pkg.sv =====
package ibmw_pkg;

    localparam int unsigned DIRECT_POINTERS = 12;
    localparam int unsigned SLOT_COUNT      = 15;
    localparam int unsigned SLOT_W          = 4;

    localparam logic [SLOT_W-1:0] SLOT_SINGLE = 4'd12;
    localparam logic [SLOT_W-1:0] SLOT_DOUBLE = 4'd13;
    localparam logic [SLOT_W-1:0] SLOT_TRIPLE = 4'd14;

    localparam logic [3:0] SHIFT_MIN   = 4'd8;
    localparam logic [3:0] SHIFT_MAX   = 4'd14;
    localparam logic [3:0] SHIFT_RESET = 4'd8;

    localparam logic [1:0] MODE_LOAD      = 2'd0;
    localparam logic [1:0] MODE_TRANSLATE = 2'd1;
    localparam logic [1:0] MODE_RESPONSE  = 2'd2;

    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_RANGE = 2'd2;

    localparam logic [16:0] FETCH_SIZE = 17'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  slot;
        logic [31:0] pointer_value;
        logic [31:0] logical_block;
        logic [15:0] byte_offset;
        logic [16:0] access_size;
        logic        is_write;
    } t_request;

    typedef struct packed {
        logic        busy;
        logic [1:0]  levels_left;
        logic [31:0] relative_index;
        logic [15:0] saved_offset;
        logic [16:0] saved_size;
        logic        saved_write;
    } t_walk_state;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] block_number;
        logic [15:0] target_offset;
        logic [16:0] target_size;
        logic        target_write;
    } t_result;

    typedef struct packed {
        logic [31:0] direct;
        logic [31:0] single;
        logic [31:0] double;
        logic [31:0] triple;
    } t_roots;

endpackage

// ===== src/ibmw_slots.sv =====
module ibmw_slots
    import ibmw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_wr_slot,
    input  logic [31:0]       i_wr_data,
    input  logic [SLOT_W-1:0] i_rd_slot,
    output t_roots            o_roots
);

    // inode pointer slots, no reset: read only after being loaded
    logic [31:0] r_slots [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_slots[i_wr_slot] <= i_wr_data;
        end
    end

    assign o_roots.direct = r_slots[i_rd_slot];
    assign o_roots.single = r_slots[SLOT_SINGLE];
    assign o_roots.double = r_slots[SLOT_DOUBLE];
    assign o_roots.triple = r_slots[SLOT_TRIPLE];

endmodule

// ===== src/ibmw_step.sv =====
module ibmw_step
    import ibmw_pkg::*;
(
    input  t_request    i_req,
    input  t_walk_state i_state,
    input  logic [3:0]  i_shift,
    input  t_roots      i_roots,
    output t_result     o_res,
    output t_walk_state o_state
);

    logic [3:0]  s;
    logic [4:0]  s2;
    logic [5:0]  s3;
    logic [31:0] mask;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] r3;
    logic [31:0] idx_dbl;
    logic [31:0] idx_tpl;
    logic [31:0] idx_rsp;
    logic [1:0]  lv_next;

    always_comb begin
        if (i_shift < SHIFT_MIN) begin
            s = SHIFT_MIN;
        end else if (i_shift > SHIFT_MAX) begin
            s = SHIFT_MAX;
        end else begin
            s = i_shift;
        end
        s2   = {s, 1'b0};
        s3   = {1'b0, s2} + {2'b00, s};
        mask = (32'd1 << s) - 32'd1;
        // relative index after each range is skipped, valid only past that range
        r1   = i_req.logical_block - 32'(DIRECT_POINTERS);
        r2   = r1 - (32'd1 << s);
        r3   = r2 - (32'd1 << s2);
        idx_dbl = r2 >> s;
        idx_tpl = r3 >> s2;
        lv_next = i_state.levels_left - 2'd1;
        idx_rsp = (lv_next == 2'd2) ? ((i_state.relative_index >> s) & mask)
                                    : (i_state.relative_index & mask);
    end

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        unique case (i_req.mode)
            MODE_LOAD: begin
            end
            MODE_TRANSLATE: begin
                o_state.saved_offset = i_req.byte_offset;
                o_state.saved_size   = i_req.access_size;
                o_state.saved_write  = i_req.is_write;
                o_state.busy         = 1'b0;
                o_state.levels_left  = 2'd0;
                o_res.valid          = 1'b1;
                o_res.target_size    = FETCH_SIZE;
                priority if (i_req.logical_block < 32'(DIRECT_POINTERS)) begin
                    o_res.kind          = KIND_DATA;
                    o_res.block_number  = i_roots.direct;
                    o_res.target_offset = i_req.byte_offset;
                    o_res.target_size   = i_req.access_size;
                    o_res.target_write  = i_req.is_write;
                end else if ((r1 >> s) == 32'd0) begin
                    o_state.busy           = 1'b1;
                    o_state.levels_left    = 2'd1;
                    o_state.relative_index = r1;
                    o_res.kind             = KIND_FETCH;
                    o_res.block_number     = i_roots.single;
                    o_res.target_offset    = {r1[13:0], 2'b00};
                end else if ((r2 >> s2) == 32'd0) begin
                    o_state.busy           = 1'b1;
                    o_state.levels_left    = 2'd2;
                    o_state.relative_index = r2;
                    o_res.kind             = KIND_FETCH;
                    o_res.block_number     = i_roots.double;
                    o_res.target_offset    = {idx_dbl[13:0], 2'b00};
                end else if ((r3 >> s3) == 32'd0) begin
                    o_state.busy           = 1'b1;
                    o_state.levels_left    = 2'd3;
                    o_state.relative_index = r3;
                    o_res.kind             = KIND_FETCH;
                    o_res.block_number     = i_roots.triple;
                    o_res.target_offset    = {idx_tpl[13:0], 2'b00};
                end else begin
                    o_res.kind        = KIND_RANGE;
                    o_res.target_size = i_req.access_size;
                end
            end
            MODE_RESPONSE: begin
                if (i_state.busy) begin
                    o_state.levels_left = lv_next;
                    o_res.valid         = 1'b1;
                    o_res.block_number  = i_req.pointer_value;
                    if (lv_next == 2'd0) begin
                        o_state.busy        = 1'b0;
                        o_res.kind          = KIND_DATA;
                        o_res.target_offset = i_state.saved_offset;
                        o_res.target_size   = i_state.saved_size;
                        o_res.target_write  = i_state.saved_write;
                    end else begin
                        o_res.kind          = KIND_FETCH;
                        o_res.target_offset = {idx_rsp[13:0], 2'b00};
                        o_res.target_size   = FETCH_SIZE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/indirect_block_map_walker_unit.sv =====
// Indirect block map walker: turns a logical block number of a file into either a data
// access or a chain of pointer fetches through the single, double or triple indirect
// blocks, using 15 inode pointer slots that must be loaded before a translation reads
// them. One request is taken every clock cycle while input ready is high. A request is
// held in the input register and is worked out while it moves into the result register,
// so its result is offered from the result register and can be taken at the next clock edge.
// Input ready drops only while the result register holds a result that is not taken.
// Each fetch response request must follow the fetch result it answers.
module indirect_block_map_walker_unit
    import ibmw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_pointer_value,
    input  logic [31:0] i_logical_block,
    input  logic [15:0] i_byte_offset,
    input  logic [16:0] i_access_size,
    input  logic        i_is_write,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_block_number,
    output logic [15:0] o_target_offset,
    output logic [16:0] o_target_size,
    output logic        o_target_write
);

    logic [3:0]  r_pointer_shift;
    logic        r_in_valid;
    t_request    r_in;
    t_walk_state r_state;
    t_walk_state n_state;
    t_result     n_res;
    t_result     r_out;
    t_roots      roots;
    logic        advance;
    logic        slot_we;

    assign advance    = r_in_valid && (!r_out.valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign slot_we    = advance && (r_in.mode == MODE_LOAD) && (r_in.slot < SLOT_W'(SLOT_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pointer_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            r_pointer_shift <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in.mode          <= i_mode;
            r_in.slot          <= i_slot;
            r_in.pointer_value <= i_pointer_value;
            r_in.logical_block <= i_logical_block;
            r_in.byte_offset   <= i_byte_offset;
            r_in.access_size   <= i_access_size;
            r_in.is_write      <= i_is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.busy           <= 1'b0;
            r_state.levels_left    <= 2'd0;
            r_state.relative_index <= 32'd0;
            r_state.saved_offset   <= 16'd0;
            r_state.saved_size     <= 17'd1;
            r_state.saved_write    <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (advance) begin
            r_out.valid <= n_res.valid;
        end else if (i_out_ready) begin
            r_out.valid <= 1'b0;
        end
        if (advance && n_res.valid) begin
            r_out.kind          <= n_res.kind;
            r_out.block_number  <= n_res.block_number;
            r_out.target_offset <= n_res.target_offset;
            r_out.target_size   <= n_res.target_size;
            r_out.target_write  <= n_res.target_write;
        end
    end

    ibmw_slots u_slots (
        .i_clk     (i_clk),
        .i_we      (slot_we),
        .i_wr_slot (r_in.slot),
        .i_wr_data (r_in.pointer_value),
        .i_rd_slot (r_in.logical_block[SLOT_W-1:0]),
        .o_roots   (roots)
    );

    ibmw_step u_step (
        .i_req   (r_in),
        .i_state (r_state),
        .i_shift (r_pointer_shift),
        .i_roots (roots),
        .o_res   (n_res),
        .o_state (n_state)
    );

    assign o_out_valid     = r_out.valid;
    assign o_kind          = r_out.kind;
    assign o_block_number  = r_out.block_number;
    assign o_target_offset = r_out.target_offset;
    assign o_target_size   = r_out.target_size;
    assign o_target_write  = r_out.target_write;

endmodule

// ===== src/ibmw_checker.sv =====
module ibmw_checker
    import ibmw_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [3:0]  i_cfg_data,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_mode,
    input logic [3:0]  i_slot,
    input logic [31:0] i_pointer_value,
    input logic [31:0] i_logical_block,
    input logic [15:0] i_byte_offset,
    input logic [16:0] i_access_size,
    input logic        i_is_write,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [31:0] o_block_number,
    input logic [15:0] o_target_offset,
    input logic [16:0] o_target_size,
    input logic        o_target_write
);

    // a stalled result keeps its kind, block number and target offset
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_block_number) && $stable(o_target_offset))
        else $error("stalled result changed");

    a_fetch_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_FETCH) |->
            (o_target_size == FETCH_SIZE) && !o_target_write && (o_target_offset[1:0] == 2'b00))
        else $error("malformed pointer fetch");

    a_range_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_RANGE) |->
            (o_block_number == 32'd0) && (o_target_offset == 16'd0) && !o_target_write)
        else $error("malformed range error");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == KIND_FETCH) || (o_kind == KIND_DATA)
            || (o_kind == KIND_RANGE))
        else $error("unknown result kind");

    // with the result register empty nothing holds back the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && $past(i_rst_n) |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind indirect_block_map_walker_unit ibmw_checker u_ibmw_checker (.*);

// ===== verif/testbench.sv =====
module testbench;
    import ibmw_pkg::*;

    localparam int unsigned STALL_LIMIT    = 4000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned PHASE_REQUESTS = 195;
    localparam int unsigned PHASE_COUNT    = 10;
    localparam logic [1:0]  MODE_UNUSED    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] block_number;
        logic [15:0] target_offset;
        logic [16:0] target_size;
        logic        target_write;
    } map_result_t;

    // raw register values, the first, the fourth and the last sit outside the legal range
    localparam logic [3:0] PHASE_SHIFTS [PHASE_COUNT] = '{
        4'd0, 4'd14, 4'd10, 4'd15, 4'd9, 4'd13, 4'd8, 4'd11, 4'd12, 4'd3
    };

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_data  = '0;
    logic        in_valid  = 1'b0;
    t_request    cur_req   = '0;
    logic        out_ready = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [31:0] o_block_number;
    logic [15:0] o_target_offset;
    logic [16:0] o_target_size;
    logic        o_target_write;

    t_request    pending_requests[$];
    map_result_t expected_maps[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned req_taken_cnt  = 0;
    int unsigned drv_seen_cnt   = 0;
    int unsigned results_seen   = 0;
    int unsigned stall_cycles   = 0;
    int unsigned error_count    = 0;

    // walker state as the block should hold it
    logic [3:0]  model_shift;
    logic [31:0] slot_table [SLOT_COUNT];
    logic        walk_busy;
    logic [1:0]  walk_levels;
    logic [31:0] walk_index;
    logic [15:0] hold_offset;
    logic [16:0] hold_size;
    logic        hold_write;

    indirect_block_map_walker_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (cur_req.mode),
        .i_slot          (cur_req.slot),
        .i_pointer_value (cur_req.pointer_value),
        .i_logical_block (cur_req.logical_block),
        .i_byte_offset   (cur_req.byte_offset),
        .i_access_size   (cur_req.access_size),
        .i_is_write      (cur_req.is_write),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_kind          (o_kind),
        .o_block_number  (o_block_number),
        .o_target_offset (o_target_offset),
        .o_target_size   (o_target_size),
        .o_target_write  (o_target_write)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned clamp_shift(input logic [3:0] raw);
        if (raw < SHIFT_MIN) return SHIFT_MIN;
        if (raw > SHIFT_MAX) return SHIFT_MAX;
        return raw;
    endfunction

    task automatic map_request(input t_request rq);
        int unsigned s;
        logic [63:0] b;
        logic [63:0] r;
        logic [31:0] mask;
        logic [31:0] idx;
        map_result_t res;
        bit          emit;
        s    = clamp_shift(model_shift);
        b    = 64'd1 << s;
        mask = b[31:0] - 32'd1;
        emit = 1'b1;
        res  = '0;
        case (rq.mode)
            MODE_LOAD: begin
                emit = 1'b0;
                if (rq.slot < SLOT_COUNT) slot_table[rq.slot] = rq.pointer_value;
            end
            MODE_TRANSLATE: begin
                r           = {32'd0, rq.logical_block};
                hold_offset = rq.byte_offset;
                hold_size   = rq.access_size;
                hold_write  = rq.is_write;
                walk_busy   = 1'b0;
                walk_levels = 2'd0;
                if (r < DIRECT_POINTERS) begin
                    res = '{KIND_DATA, slot_table[r[3:0]], hold_offset, hold_size, hold_write};
                end else begin
                    r = r - DIRECT_POINTERS;
                    if (r < b) begin
                        walk_busy   = 1'b1;
                        walk_levels = 2'd1;
                        walk_index  = r[31:0];
                        res = '{KIND_FETCH, slot_table[SLOT_SINGLE], 16'(r << 2), FETCH_SIZE, 1'b0};
                    end else begin
                        r = r - b;
                        if (r < (b << s)) begin
                            walk_busy   = 1'b1;
                            walk_levels = 2'd2;
                            walk_index  = r[31:0];
                            res = '{KIND_FETCH, slot_table[SLOT_DOUBLE], 16'((r >> s) << 2),
                                    FETCH_SIZE, 1'b0};
                        end else begin
                            r = r - (b << s);
                            if (r < (b << (2 * s))) begin
                                walk_busy   = 1'b1;
                                walk_levels = 2'd3;
                                walk_index  = r[31:0];
                                res = '{KIND_FETCH, slot_table[SLOT_TRIPLE],
                                        16'((r >> (2 * s)) << 2), FETCH_SIZE, 1'b0};
                            end else begin
                                res = '{KIND_RANGE, 32'd0, 16'd0, hold_size, 1'b0};
                            end
                        end
                    end
                end
            end
            MODE_RESPONSE: begin
                if (!walk_busy) begin
                    emit = 1'b0;
                end else begin
                    walk_levels = walk_levels - 2'd1;
                    if (walk_levels == 2'd0) begin
                        walk_busy = 1'b0;
                        res = '{KIND_DATA, rq.pointer_value, hold_offset, hold_size, hold_write};
                    end else begin
                        idx = (walk_levels == 2'd2) ? ((walk_index >> s) & mask)
                                                    : (walk_index & mask);
                        res = '{KIND_FETCH, rq.pointer_value, 16'(idx << 2), FETCH_SIZE, 1'b0};
                    end
                end
            end
            default: emit = 1'b0;
        endcase
        if (emit) expected_maps.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            error_count++;
        end
    endtask

    function automatic t_request random_request();
        t_request rq;
        rq.mode          = 2'($urandom_range(0, 3));
        rq.slot          = 4'($urandom);
        rq.pointer_value = $urandom;
        rq.logical_block = $urandom;
        rq.byte_offset   = 16'($urandom);
        rq.access_size   = 17'($urandom_range(1, 65536));
        rq.is_write      = 1'($urandom);
        return rq;
    endfunction

    task automatic queue_request(input logic [1:0] mode, input logic [3:0] slot,
                                 input logic [31:0] pval, input logic [31:0] lblk,
                                 input logic [15:0] offs, input logic [16:0] size,
                                 input logic wr);
        pending_requests.push_back('{mode, slot, pval, lblk, offs, size, wr});
    endtask

    // mostly complete walks into every region, some cut short or over-answered
    task automatic queue_walks(input int unsigned n, input logic [3:0] shift_raw);
        int unsigned count;
        int unsigned region;
        int unsigned replies;
        int unsigned k;
        int unsigned s;
        logic [63:0] b;
        logic [63:0] top;
        logic [63:0] lo [5];
        logic [63:0] span [5];
        logic [63:0] offs;
        t_request    rq;
        s       = clamp_shift(shift_raw);
        b       = 64'd1 << s;
        top     = 64'h1_0000_0000;
        lo[0]   = 0;
        span[0] = DIRECT_POINTERS;
        lo[1]   = DIRECT_POINTERS;
        span[1] = b;
        lo[2]   = lo[1] + b;
        span[2] = b << s;
        lo[3]   = lo[2] + span[2];
        span[3] = b << (2 * s);
        lo[4]   = lo[3] + span[3];
        span[4] = top;
        for (k = 0; k < 5; k++) begin
            if (lo[k] >= top) span[k] = 0;
            else if (lo[k] + span[k] > top) span[k] = top - lo[k];
        end
        count = 0;
        while (count < n) begin
            if ($urandom_range(99) < 12) begin
                pending_requests.push_back(random_request());
                count++;
            end else begin
                region = $urandom_range(0, 4);
                while (span[region] == 0) region--;
                case ($urandom_range(0, 3))
                    0:       offs = 0;
                    1:       offs = span[region] - 1;
                    default: offs = {$urandom, $urandom} % span[region];
                endcase
                rq               = random_request();
                rq.mode          = MODE_TRANSLATE;
                rq.logical_block = 32'(lo[region] + offs);
                pending_requests.push_back(rq);
                count++;
                replies = (region >= 1 && region <= 3) ? region : 0;
                k = $urandom_range(99);
                if (k < 10 && replies > 0) replies = $urandom_range(0, replies - 1);
                else if (k < 15) replies++;
                for (k = 0; k < replies; k++) begin
                    rq      = random_request();
                    rq.mode = MODE_RESPONSE;
                    pending_requests.push_back(rq);
                    count++;
                end
            end
        end
    endtask

    task automatic write_shift(input logic [3:0] value);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_valid || expected_maps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        logic hold;
        hold = in_valid;
        if (hold && req_taken_cnt != drv_seen_cnt) begin
            drv_seen_cnt = req_taken_cnt;
            hold = 1'b0;
        end
        // a fetch reply may only go in once the fetch it answers has come out
        if (!hold && pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct
                && !(pending_requests[0].mode == MODE_RESPONSE && expected_maps.size() != 0))
        begin
            cur_req <= pending_requests.pop_front();
            hold = 1'b1;
        end
        in_valid <= hold;
    end

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        map_result_t want;
        bit          moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            model_shift = SHIFT_RESET;
            walk_busy   = 1'b0;
            walk_levels = 2'd0;
            walk_index  = '0;
            hold_offset = '0;
            hold_size   = 17'd1;
            hold_write  = 1'b0;
        end else begin
            if (cfg_we) begin
                model_shift = cfg_data;
                moved = 1'b1;
            end
            if (o_out_valid && out_ready) begin
                moved = 1'b1;
                results_seen++;
                if (expected_maps.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d block %0h",
                             $time, o_kind, o_block_number);
                    error_count++;
                end else begin
                    want = expected_maps.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("block_number", want.block_number, o_block_number);
                    check_field("target_offset", want.target_offset, o_target_offset);
                    check_field("target_size", want.target_size, o_target_size);
                    check_field("target_write", want.target_write, o_target_write);
                end
            end
            if (in_valid && o_in_ready) begin
                moved = 1'b1;
                map_request(cur_req);
                req_taken_cnt++;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned p;
        int unsigned k;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        write_shift(SHIFT_RESET);

        // every slot loaded before anything reads it
        for (k = 0; k < SLOT_COUNT; k++)
            queue_request(MODE_LOAD, 4'(k), (k == 0) ? 32'd0 : (k == 1) ? '1 : $urandom,
                          32'd0, 16'd0, 17'd1, 1'b0);
        queue_request(MODE_LOAD, 4'd15, 32'hDEAD_BEEF, '1, '1, 17'h1_0000, 1'b1);
        queue_request(MODE_UNUSED, 4'd3, $urandom, 32'd5, 16'h00FF, 17'd64, 1'b1);
        queue_request(MODE_RESPONSE, 4'd0, 32'h1234_5678, 32'd0, 16'd0, 17'd1, 1'b0);
        queue_request(MODE_TRANSLATE, 4'd0, 32'd0, 32'd0, 16'hFFFF, 17'h1_0000, 1'b1);
        queue_request(MODE_TRANSLATE, 4'd0, 32'd0, 32'd12, 16'h0123, 17'd512, 1'b1);
        queue_request(MODE_RESPONSE, 4'd0, '1, 32'd0, 16'd0, 17'd1, 1'b0);
        // a double walk that a new translation cuts short
        queue_request(MODE_TRANSLATE, 4'd0, 32'd0, 32'd268, 16'h0004, 17'd4, 1'b0);
        queue_request(MODE_TRANSLATE, 4'd0, 32'd0, 32'd11, 16'd0, 17'd1, 1'b0);
        queue_request(MODE_RESPONSE, 4'd0, 32'h0BAD_0BAD, 32'd0, 16'd0, 17'd1, 1'b0);
        queue_request(MODE_TRANSLATE, 4'd0, 32'd0, 32'd65804, 16'h8000, 17'd1024, 1'b1);
        queue_request(MODE_RESPONSE, 4'd0, 32'h0001_0000, 32'd0, 16'd0, 17'd1, 1'b0);
        queue_request(MODE_RESPONSE, 4'd0, 32'h8000_0001, 32'd0, 16'd0, 17'd1, 1'b0);
        queue_request(MODE_RESPONSE, 4'd0, 32'h7FFF_FFFE, 32'd0, 16'd0, 17'd1, 1'b0);
        queue_request(MODE_TRANSLATE, 4'd0, 32'd0, '1, 16'h5555, 17'h0_AAAA, 1'b1);
        wait_idle();

        for (p = 0; p < PHASE_COUNT; p++) begin
            write_shift(PHASE_SHIFTS[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            queue_walks(PHASE_REQUESTS, PHASE_SHIFTS[p]);
            wait_idle();
        end

        $display("run covered %0d requests and %0d results across %0d shift settings",
                 req_taken_cnt, results_seen, PHASE_COUNT + 1);
        $display("with direct, single, double and triple walks, range errors and aborts");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
